[hdl/gb3_pkg.sv]
// Types and constants shared by the 3x3 binomial blur block.
package gb3_pkg;

  localparam int PIX_W  = 16;
  localparam int FW_W   = 11;
  localparam int FH_W   = 12;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [FW_W-1:0] FW_RESET = 11'd80;
  localparam logic [FH_W-1:0] FH_RESET = 12'd80;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] gray;
  } in_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             frame_end;
  } out_res_t;

endpackage

[hdl/gaussian_blur_3x3_replicate.sv]
// 3x3 binomial blur over a raster pixel stream with replicated frame edges.
// A result passes the first-stage and output registers after the request that releases it.
// One request per cycle unless stalled, each row store doing at most one read and one write.
// Two row memories alternate by row parity; a two-column window of column sums feeds the sum.
// Reset clears the counters and pipeline valids and sets the frame size to 80 x 80;
// row memories are not cleared.
module gaussian_blur_3x3_replicate #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  gb3_pkg::in_req_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output gb3_pkg::out_res_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gb3_pkg::ADDR_W-1:0]  paddr,
  input  logic [gb3_pkg::DATA_W-1:0]  pwdata,
  output logic [gb3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > gb3_pkg::FW_W) ? WW : gb3_pkg::FW_W;
  localparam int RW   = gb3_pkg::FH_W;
  localparam int PW   = gb3_pkg::PIX_W;
  localparam int COLW = PW + 2;
  localparam int SUMW = PW + 4;
  localparam logic [SUMW-1:0] ROUND_BIAS = SUMW'(8);

  // configuration
  logic [gb3_pkg::FW_W-1:0] fw_r;
  logic [gb3_pkg::FH_W-1:0] fh_r;
  logic                     cfg_wr;
  logic                     cfg_idx;

  // frame position
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [WW-1:0] dcnt_r, dcnt_nxt;

  logic [WW-1:0]   w_eff, w_last;
  logic [CMPW-1:0] fw_ext;
  logic [RW-1:0]   h_eff, h_last;
  logic            draining, is_drain, in_acc;
  logic            step_pix, step_drn, step;
  logic            col_last, row_last, h_one, w_one;
  logic            j_end, j_zero, j_one;
  logic [CW-1:0]   rd_addr;

  // row memories
  logic [PW-1:0] row_mem0 [MAX_WIDTH];
  logic [PW-1:0] row_mem1 [MAX_WIDTH];
  logic [PW-1:0] rd0_r, rd1_r;

  // first stage
  logic          s1_vld_r, s1_vld_nxt;
  logic          s1_emit_r, s1_wupd_r, s1_x0_r, s1_lc1_r, s1_top_same_r;
  logic          s1_bot_mid_r, s1_init_r, s1_prev_r, s1_end_r;
  logic [PW-1:0] s1_pix_r;
  logic          st_emit, st_wupd, st_x0, st_lc1, st_top_same, st_bot_mid, st_init, st_end;
  logic          s1_go, out_free;

  // window and result
  logic [COLW-1:0] c0_r, c1_r;
  logic [PW-1:0]   mid, pp, top, bot;
  logic [COLW-1:0] new_col, left_col, right_col;
  logic [SUMW-1:0] sum, rounded;
  logic            out_vld_r, out_vld_nxt;
  gb3_pkg::out_res_t out_res_r, out_res_nxt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[gb3_pkg::ADDR_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= gb3_pkg::FW_RESET;
      fh_r <= gb3_pkg::FH_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        gb3_pkg::REG_FRAME_WIDTH:  fw_r <= pwdata[gb3_pkg::FW_W-1:0];
        gb3_pkg::REG_FRAME_HEIGHT: fh_r <= pwdata[gb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      gb3_pkg::REG_FRAME_WIDTH:  prdata = gb3_pkg::DATA_W'(fw_r);
      gb3_pkg::REG_FRAME_HEIGHT: prdata = gb3_pkg::DATA_W'(fh_r);
      default:                   prdata = '0;
    endcase
  end

  assign fw_ext = CMPW'(fw_r);
  assign w_eff  = (fw_r == '0) ? WW'(1) :
                  (fw_ext > CMPW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
  assign w_last = w_eff - WW'(1);
  assign h_eff  = (fh_r == '0) ? RW'(1) : fh_r;
  assign h_last = h_eff - RW'(1);

  assign draining = in_row_r >= h_eff;
  assign is_drain = in_data.action == gb3_pkg::ACT_DRAIN;
  assign in_acc   = in_valid && !in_stall;
  assign step_pix = in_acc && !is_drain && !draining;
  assign step_drn = in_acc && is_drain && draining;
  assign step     = step_pix || step_drn;

  assign col_last = WW'(in_col_r) == w_last;
  assign row_last = in_row_r == h_last;
  assign h_one    = h_eff == RW'(1);
  assign w_one    = w_eff == WW'(1);
  assign j_end    = dcnt_r == w_eff;
  assign j_zero   = dcnt_r == '0;
  assign j_one    = dcnt_r == WW'(1);

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    dcnt_nxt   = dcnt_r;
    if (cfg_wr) begin
      in_col_nxt = '0;
      in_row_nxt = '0;
      dcnt_nxt   = '0;
    end else if (step_pix) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
        if (row_last) begin
          dcnt_nxt = h_one ? WW'(1) : '0;
        end
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end else if (step_drn) begin
      if (j_end) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
        dcnt_nxt   = '0;
      end else begin
        dcnt_nxt = dcnt_r + WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
      dcnt_r   <= '0;
    end else begin
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      dcnt_r   <= dcnt_nxt;
    end
  end

  assign rd_addr = step_drn ? (j_end ? '0 : dcnt_r[CW-1:0]) : in_col_r;

  always_ff @(posedge clk) begin
    if (step) begin
      rd0_r <= row_mem0[rd_addr];
    end
    if (step_pix && !in_row_r[0]) begin
      row_mem0[in_col_r] <= in_data.gray;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rd1_r <= row_mem1[rd_addr];
    end
    if (step_pix && in_row_r[0]) begin
      row_mem1[in_col_r] <= in_data.gray;
    end
  end

  always_comb begin
    if (step_drn) begin
      st_emit     = 1'b1;
      st_init     = 1'b0;
      st_wupd     = 1'b1;
      st_x0       = j_zero || j_end;
      st_lc1      = (j_zero || j_end) ? w_one : j_one;
      st_top_same = h_one;
      st_bot_mid  = 1'b1;
      st_end      = j_end;
    end else begin
      st_emit     = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
      st_init     = h_one && (in_row_r == '0) && (in_col_r == '0);
      st_wupd     = (in_row_r != '0) || st_init;
      st_x0       = in_col_r == '0;
      st_lc1      = (in_col_r == '0) ? w_one : (in_col_r == CW'(1));
      st_top_same = in_row_r == RW'(1);
      st_bot_mid  = 1'b0;
      st_end      = 1'b0;
    end
  end

  assign out_free   = !out_vld_r || !out_stall;
  assign s1_go      = s1_vld_r && (!s1_emit_r || out_free);
  assign in_stall   = s1_vld_r && !s1_go;
  assign s1_vld_nxt = step ? 1'b1 : (s1_go ? 1'b0 : s1_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_emit_r     <= st_emit;
      s1_wupd_r     <= st_wupd;
      s1_x0_r       <= st_x0;
      s1_lc1_r      <= st_lc1;
      s1_top_same_r <= st_top_same;
      s1_bot_mid_r  <= st_bot_mid;
      s1_init_r     <= st_init;
      s1_prev_r     <= ~in_row_r[0];
      s1_end_r      <= st_end;
      s1_pix_r      <= in_data.gray;
    end
  end

  assign mid     = s1_prev_r ? rd1_r : rd0_r;
  assign pp      = s1_prev_r ? rd0_r : rd1_r;
  assign top     = s1_top_same_r ? mid : pp;
  assign bot     = s1_bot_mid_r ? mid : s1_pix_r;
  assign new_col = s1_init_r ? {s1_pix_r, 2'b00}
                             : COLW'(top) + COLW'({mid, 1'b0}) + COLW'(bot);

  assign left_col  = s1_lc1_r ? c1_r : c0_r;
  assign right_col = s1_x0_r ? c1_r : new_col;
  assign sum       = SUMW'(left_col) + SUMW'({c1_r, 1'b0}) + SUMW'(right_col);
  assign rounded   = sum + ROUND_BIAS;

  // advance the column window
  always_ff @(posedge clk) begin
    if (s1_go && s1_wupd_r) begin
      c0_r <= c1_r;
      c1_r <= new_col;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (s1_go && s1_emit_r) begin
      out_vld_nxt           = 1'b1;
      out_res_nxt.blurred   = rounded[SUMW-1:4];
      out_res_nxt.frame_end = s1_end_r;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_res_r;

endmodule
